[src/spn16_block_cipher_defines.svh]
// Assertion macros used by the cipher RTL.
`ifndef SPN16_BLOCK_CIPHER_DEFINES_SVH
`define SPN16_BLOCK_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS

`define SPN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

`define SPN_ASSERT_DELAY(label, clk, rst_n, ante, cons, dly) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("assertion failed: label");

`else

`define SPN_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define SPN_ASSERT_DELAY(label, clk, rst_n, ante, cons, dly)

`endif

`endif

[src/spn16_pkg.sv]
// Constants, S-box tables and round functions of the 16-bit SPN cipher.
`default_nettype none

package spn16_pkg;

    localparam int BLOCK_W   = 16;
    localparam int KEY_W     = 16;
    localparam int NUM_KEYS  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int SPN_ROUNDS = 5;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [3:0] nibble_t;

    localparam nibble_t FWD_SBOX [16] = '{
        4'd2, 4'd8, 4'd13, 4'd5, 4'd4, 4'd10, 4'd12, 4'd15,
        4'd14, 4'd3, 4'd11, 4'd9, 4'd7, 4'd1, 4'd6, 4'd0
    };

    localparam nibble_t INV_SBOX [16] = '{
        4'd15, 4'd13, 4'd0, 4'd9, 4'd4, 4'd3, 4'd14, 4'd12,
        4'd1, 4'd11, 4'd5, 4'd10, 4'd6, 4'd2, 4'd8, 4'd7
    };

    function automatic block_t sub_fwd(input block_t v);
        block_t r;
        r = '0;
        for (int n = 0; n < 4; n++)
        begin
            r[n*4 +: 4] = FWD_SBOX[v[n*4 +: 4]];
        end
        return r;
    endfunction

    function automatic block_t sub_inv(input block_t v);
        block_t r;
        r = '0;
        for (int n = 0; n < 4; n++)
        begin
            r[n*4 +: 4] = INV_SBOX[v[n*4 +: 4]];
        end
        return r;
    endfunction

    // The block is a 4x4 bit matrix read from the most significant bit;
    // row r and column c trade places.
    function automatic block_t bit_transpose(input block_t v);
        block_t r;
        r = '0;
        for (int row = 0; row < 4; row++)
        begin
            for (int col = 0; col < 4; col++)
            begin
                r[15 - (4*col + row)] = v[15 - (4*row + col)];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/spn16_block_cipher.sv]
// Top level of the pipelined 16-bit SPN block cipher.
// A new item is taken in every clock cycle, and busy is always low. Each item
// passes an input stage, one stage per cipher round and an output stage. Its
// result is on block_out with done once it has passed all of these stages.
// Results come out in the order the items came in. The receiver cannot stall
// the output, and none is needed. Round keys should be written only while no
// item is in the pipeline.
`default_nettype none

module spn16_block_cipher #(
    parameter int ROUNDS = spn16_pkg::SPN_ROUNDS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           opcode,
    input  wire logic [spn16_pkg::BLOCK_W-1:0]  block_in,
    output logic                                done,
    output logic [spn16_pkg::BLOCK_W-1:0]       block_out,
    input  wire logic                           cfg_we,
    input  wire logic [spn16_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spn16_pkg::KEY_W-1:0]    cfg_data
);

    import spn16_pkg::*;

`include "spn16_block_cipher_defines.svh"

    logic [KEY_W-1:0] key_reg [NUM_KEYS];
    logic [KEY_W-1:0] key_next [NUM_KEYS];

    logic   valid_reg [ROUNDS];
    logic   valid_next [ROUNDS];
    logic   op_reg [ROUNDS];
    logic   op_next [ROUNDS];
    block_t data_reg [ROUNDS];
    block_t data_next [ROUNDS];

    logic   done_reg;
    logic   done_next;
    block_t out_reg;
    block_t out_next;

    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_next[k] = key_reg[k];
            if (cfg_we && (cfg_index == CFG_IDX_W'(k)))
            begin
                key_next[k] = cfg_data;
            end
        end
    end

    assign busy = 1'b0;

    // Decryption strips the final whitening key on the way in.
    assign valid_next[0] = start && !busy;
    assign op_next[0]    = opcode;
    assign data_next[0]  = (opcode == OP_DECRYPT) ? (block_in ^ key_reg[ROUNDS-1]) : block_in;

    for (genvar s = 0; s < ROUNDS - 1; s++)
    begin : g_round
        block_t enc_val;
        block_t dec_val;

        assign enc_val = bit_transpose(sub_fwd(data_reg[s] ^ key_reg[s]));
        assign dec_val = sub_inv(bit_transpose(data_reg[s])) ^ key_reg[ROUNDS-2-s];

        assign valid_next[s+1] = valid_reg[s];
        assign op_next[s+1]    = op_reg[s];
        assign data_next[s+1]  = (op_reg[s] == OP_DECRYPT) ? dec_val : enc_val;
    end

    assign done_next = valid_reg[ROUNDS-1];
    assign out_next  = (op_reg[ROUNDS-1] == OP_ENCRYPT)
                     ? (data_reg[ROUNDS-1] ^ key_reg[ROUNDS-1])
                     : data_reg[ROUNDS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                key_reg[k] <= '0;
            end
            for (int s = 0; s < ROUNDS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                key_reg[k] <= key_next[k];
            end
            for (int s = 0; s < ROUNDS; s++)
            begin
                valid_reg[s] <= valid_next[s];
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ROUNDS; s++)
        begin
            op_reg[s]   <= op_next[s];
            data_reg[s] <= data_next[s];
        end
        out_reg <= out_next;
    end

    assign done      = done_reg;
    assign block_out = out_reg;

    `SPN_ASSERT_DELAY(a_item_done, clk, rst_n, start && !busy, done, ROUNDS+1)
    `SPN_ASSERT_DELAY(a_no_spurious_done, clk, rst_n, !(start && !busy), !done, ROUNDS+1)
    `SPN_ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy)

endmodule

`default_nettype wire

[tb/tb_spn16_block_cipher.sv]
// Self-checking testbench for the 16-bit SPN block cipher with its own cipher predictor.
`default_nettype none

module tb_spn16_block_cipher;

    timeunit 1ns;
    timeprecision 1ps;

    import spn16_pkg::*;

    localparam int ROUNDS = SPN_ROUNDS;
    localparam int IDLE_LIMIT = 400;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 96;

    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_KEY_4 = 3'd4;

    localparam logic [3:0] ENC_SBOX [16] = '{
        4'd2, 4'd8, 4'd13, 4'd5, 4'd4, 4'd10, 4'd12, 4'd15,
        4'd14, 4'd3, 4'd11, 4'd9, 4'd7, 4'd1, 4'd6, 4'd0
    };
    localparam logic [3:0] DEC_SBOX [16] = '{
        4'd15, 4'd13, 4'd0, 4'd9, 4'd4, 4'd3, 4'd14, 4'd12,
        4'd1, 4'd11, 4'd5, 4'd10, 4'd6, 4'd2, 4'd8, 4'd7
    };

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 opcode;
    logic [BLOCK_W-1:0]   block_in;
    logic                 done;
    logic [BLOCK_W-1:0]   block_out;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_W-1:0]     cfg_data;

    logic [KEY_W-1:0]   round_keys [NUM_KEYS];
    logic [BLOCK_W-1:0] expected_blocks [$];
    int                 fail_count;
    int                 idle_cycles;
    bit                 no_gaps;
    logic               last_op;
    logic [BLOCK_W-1:0] last_result;

    spn16_block_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .block_in  (block_in),
        .done      (done),
        .block_out (block_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [BLOCK_W-1:0] sbox_layer(input logic [BLOCK_W-1:0] v,
                                                      input bit inverse);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int n = 0; n < 4; n++)
        begin
            r[4*n +: 4] = inverse ? DEC_SBOX[v[4*n +: 4]] : ENC_SBOX[v[4*n +: 4]];
        end
        return r;
    endfunction

    // Bit p, counted from the MSB as row*4+col, moves to col*4+row.
    function automatic logic [BLOCK_W-1:0] bit_swap(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int p = 0; p < 16; p++)
        begin
            r[15 - (4 * (p % 4) + p / 4)] = v[15 - p];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] cipher_block(input logic op,
                                                        input logic [BLOCK_W-1:0] blk);
        logic [BLOCK_W-1:0] v;
        v = blk;
        if (op == OP_ENCRYPT)
        begin
            for (int r = 0; r < ROUNDS - 1; r++)
            begin
                v = bit_swap(sbox_layer(v ^ round_keys[r], 1'b0));
            end
            v = v ^ round_keys[ROUNDS - 1];
        end
        else
        begin
            v = v ^ round_keys[ROUNDS - 1];
            for (int r = 0; r < ROUNDS - 1; r++)
            begin
                v = sbox_layer(bit_swap(v), 1'b1) ^ round_keys[ROUNDS - 2 - r];
            end
        end
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return KEY_W'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_blocks.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("Unexpected result: block_out=%h", block_out);
            end
            else
            begin
                if (block_out !== expected_blocks[0])
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("Mismatch on block_out: expected %h, got %h",
                                 expected_blocks[0], block_out);
                end
                void'(expected_blocks.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_block(input logic op, input logic [BLOCK_W-1:0] blk);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        block_in <= blk;
        do
            @(posedge clk);
        while (busy);
        last_op     = op;
        last_result = cipher_block(op, blk);
        expected_blocks.push_back(last_result);
    endtask

    task automatic finish_items();
        start <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (ROUNDS + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx < NUM_KEYS)
            round_keys[idx] = data;
    endtask

    task automatic load_keys(input logic [KEY_W-1:0] k0, input logic [KEY_W-1:0] k1,
                             input logic [KEY_W-1:0] k2, input logic [KEY_W-1:0] k3,
                             input logic [KEY_W-1:0] k4);
        finish_items();
        write_reg(REG_ROUND_KEY_0, k0);
        write_reg(REG_ROUND_KEY_1, k1);
        write_reg(REG_ROUND_KEY_2, k2);
        write_reg(REG_ROUND_KEY_3, k3);
        write_reg(REG_ROUND_KEY_4, k4);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_keys();
        send_block(OP_ENCRYPT, 16'h0000);
        send_block(OP_DECRYPT, 16'h0000);
        send_block(OP_ENCRYPT, 16'hFFFF);
        send_block(OP_DECRYPT, 16'hFFFF);
    endtask

    task automatic test_block_extremes();
        logic [BLOCK_W-1:0] patterns [6];
        patterns = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555};
        load_keys(16'h3A94, 16'hA94D, 16'h94D6, 16'h4D63, 16'hD63F);
        for (int i = 0; i < 6; i++)
        begin
            send_block(OP_ENCRYPT, patterns[i]);
            send_block(OP_DECRYPT, patterns[i]);
        end
    endtask

    task automatic test_key_extremes();
        load_keys(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_block(OP_ENCRYPT, 16'h0000);
        send_block(OP_DECRYPT, 16'hFFFF);
        load_keys(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_block(OP_ENCRYPT, 16'h1234);
        send_block(OP_DECRYPT, last_result);
    endtask

    // Writes to indexes past the last key must leave every key untouched.
    task automatic test_unused_index();
        finish_items();
        write_reg(REG_ROUND_KEY_0, 16'h0F0F);
        write_reg(REG_ROUND_KEY_1, 16'hF0F0);
        write_reg(REG_ROUND_KEY_2, 16'h00FF);
        write_reg(REG_ROUND_KEY_3, 16'hFF00);
        write_reg(REG_ROUND_KEY_4, 16'h6969);
        for (int j = NUM_KEYS; j < (1 << CFG_IDX_W); j++)
            write_reg(CFG_IDX_W'(j), 16'hFFFF ^ KEY_W'(j));
        cfg_we <= 1'b0;
        send_block(OP_ENCRYPT, 16'hC0DE);
        send_block(OP_DECRYPT, last_result);
        send_block(OP_ENCRYPT, 16'h7FFE);
        send_block(OP_DECRYPT, 16'h8001);
    endtask

    // Random keys per phase; about a third of the items apply the opposite operation to the previous result.
    task automatic test_random_traffic();
        logic               op;
        logic [BLOCK_W-1:0] blk;
        int                 pace;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            no_gaps = 1'b0;
            load_keys(random_key(), random_key(), random_key(), random_key(), random_key());
            pace = phase % 3;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                no_gaps = (pace == 1) || (pace == 2 && ((n / 24) % 2) == 1);
                if (n > 0 && $urandom_range(0, 2) == 0)
                begin
                    op  = ~last_op;
                    blk = last_result;
                end
                else
                begin
                    op  = 1'($urandom_range(0, 1));
                    blk = BLOCK_W'($urandom);
                end
                send_block(op, blk);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_ENCRYPT;
        block_in    = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        fail_count  = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        last_op     = OP_ENCRYPT;
        last_result = '0;
        for (int k = 0; k < NUM_KEYS; k++)
            round_keys[k] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_keys();
        test_block_extremes();
        test_key_extremes();
        test_unused_index();
        test_random_traffic();
        finish_items();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/spn16_pkg.sv
src/spn16_block_cipher.sv
tb/tb_spn16_block_cipher.sv
